FILE: src/trlen_pkg.sv
// Shared types, constants and helpers for the track resample length error block.
package trlen_pkg;

	localparam int COORD_FRAC_BITS = 16;
	localparam int COORD_W = 32;
	localparam int STAMP_W = 31;
	localparam int LEN_W = 48;
	localparam int PCT_W = 23;
	localparam int CNT_W = 32;
	localparam int DIV_NUM_W = 72;
	localparam int DIV_DEN_W = 48;
	localparam int DIV_CNT_W = 7;
	localparam int RAD_W = 66;
	localparam int ROOT_W = 33;
	localparam int SQRT_CNT_W = 6;

	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 7'd72;
	localparam logic [SQRT_CNT_W-1:0] SQRT_STEPS = 6'd33;
	localparam logic [LEN_W-1:0] LEN_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [PCT_W-1:0] PCT_FULL = 23'd6553600;
	localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FDIV,
		ST_DSQX,
		ST_DSQY,
		ST_DROOT,
		ST_KDIV,
		ST_IMUL,
		ST_IADD,
		ST_IDIV,
		ST_FIN,
		ST_PCT,
		ST_PCTDIV,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		RET_TRUE,
		RET_S1,
		RET_S2,
		RET_FINAL
	} dist_ret_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
		logic [DIV_DEN_W-1:0] rem;
	} div_rsp_t;

	// magnitude of a - b for two signed coordinates
	function automatic logic [COORD_W:0] absdiff(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		logic [COORD_W:0] d;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		return d[COORD_W] ? (~d + 1'b1) : d;
	endfunction

	// saturating length sum
	function automatic logic [LEN_W-1:0] len_add(input logic [LEN_W-1:0] a,
			input logic [LEN_W-1:0] b);
		logic [LEN_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= {1'b0, LEN_MAX}) ? LEN_MAX : s[LEN_W-1:0];
	endfunction

endpackage

FILE: src/trlen_div.sv
// Restoring divider, one quotient bit per cycle.
module trlen_div
	import trlen_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_NUM_W-1:0] work_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 ge;
	logic [DIV_DEN_W:0]   rem_next;

	assign trial = {rem_q, work_q[DIV_NUM_W-1]};
	assign ge = trial >= {1'b0, den_q};
	assign rem_next = ge ? (trial - {1'b0, den_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next[DIV_DEN_W-1:0];
			work_q <= {work_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = work_q;
	assign rsp.rem = rem_q;

endmodule

FILE: src/trlen_sqrt.sv
// Integer square root, one root bit per cycle.
module trlen_sqrt
	import trlen_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  rad,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [RAD_W-1:0]      work_q;
	logic [ROOT_W+2:0]     rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [ROOT_W+2:0]     rem_sh;
	logic [ROOT_W+2:0]     trial;
	logic                  ge;

	assign rem_sh = {rem_q[ROOT_W:0], work_q[RAD_W-1:RAD_W-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= SQRT_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= rad;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			work_q <= {work_q[RAD_W-3:0], 2'b00};
			rem_q <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: src/track_resample_length_error.sv
// Top level: waypoint sequencer around a shared multiplier, divider and square root.
//
//  channel   dir  handshake               payload
//  s_*       in   s_tvalid / s_tready     tdata: pos_x, pos_y, stamp; tlast: final_point
//  m_*       out  m_tvalid / m_tready     tdata: error_percent, sample_count;
//                                         tuser: zero_length_fault
//  cfg_*     in   cfg_wr_en               cfg_wr_data: sample_period
//
// Work: a first waypoint takes one division; a later waypoint with no sample one
// root; with samples five divisions of 72 steps and three roots of 33 steps. The
// final waypoint adds a root and at most one division. s_tready is high only while
// the sequencer idles.
// Reset clears the sequencer and the result valid flag and sets sample_period to 1.
// A result waits in the output register; the next waypoint is taken meanwhile, and a
// second result stalls the sequencer until the first transfer is done.
module track_resample_length_error
	import trlen_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // pos_x[31:0], pos_y[63:32], stamp[94:64], zero[95]
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [55:0]  m_tdata,   // error_percent[22:0], sample_count[54:23], zero[55]
	output logic         m_tuser,   // zero_length_fault[0]
	input  logic         cfg_wr_en,
	input  logic [30:0]  cfg_wr_data
);

	state_t    state_q, state_d;
	dist_ret_t ret_q;
	logic [1:0] idx_q;
	logic       seen_q;

	logic [STAMP_W-1:0] period_q;
	logic [STAMP_W-1:0] per_q;
	logic [STAMP_W-1:0] per_in;

	logic [COORD_W-1:0] cur_x_q, cur_y_q, prev_x_q, prev_y_q;
	logic [STAMP_W-1:0] cur_st_q, prev_st_q;
	logic               cur_fin_q;
	logic [31:0]        nst_q, tl_q, kq_q;
	logic [COORD_W-1:0] sl_x_q, sl_y_q, fx_q, fy_q, lx_q, ly_q;
	logic [COORD_W-1:0] ax_q, ay_q, bx_q, by_q;
	logic [LEN_W-1:0]   true_q, samp_q;
	logic [CNT_W-1:0]   pts_q;
	logic [RAD_W-1:0]   prod_q;
	logic [PCT_W-1:0]   pct_q;
	logic               fault_q;

	logic               out_valid_q;
	logic [PCT_W-1:0]   out_pct_q;
	logic [CNT_W-1:0]   out_cnt_q;
	logic               out_fault_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic              sqrt_start, sqrt_done;
	logic [ROOT_W-1:0] sqrt_root;

	logic               s_acc;
	logic [COORD_W:0]   mul_a, mul_b;
	logic [RAD_W-1:0]   product;
	logic [COORD_W-1:0] ip1, ip2;
	logic [31:0]        ioff, off_f, off_l, dt;
	logic               sample_ok;
	logic [LEN_W-1:0]   dist_len;
	logic [COORD_W:0]   sdiff, ires;
	logic [LEN_W-1:0]   diff;
	logic [54:0]        num100;
	logic [32:0]        kval;
	logic [33:0]        pts_sum;
	logic [32:0]        nst_next;
	logic               out_free;

	assign s_acc = s_tvalid & s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign per_in = (period_q == '0) ? 31'd1 : period_q;
	assign out_free = !out_valid_q || m_tready;

	// interpolation operands: idx bit 0 picks the axis, bit 1 first or last sample
	assign ip1 = idx_q[0] ? prev_y_q : prev_x_q;
	assign ip2 = idx_q[0] ? cur_y_q : cur_x_q;
	assign off_f = nst_q - {1'b0, prev_st_q};
	assign off_l = tl_q - {1'b0, prev_st_q};
	assign ioff = idx_q[1] ? off_l : off_f;
	assign dt = {1'b0, cur_st_q} - {1'b0, prev_st_q};
	assign sdiff = {ip2[COORD_W-1], ip2} - {ip1[COORD_W-1], ip1};
	assign ires = sdiff[COORD_W] ? ({ip1[COORD_W-1], ip1} - div_rsp.quo[COORD_W:0])
	                             : ({ip1[COORD_W-1], ip1} + div_rsp.quo[COORD_W:0]);

	assign sample_ok = (nst_q < {1'b0, cur_st_q}) && (nst_q >= {1'b0, prev_st_q});
	assign dist_len = {{(LEN_W-ROOT_W){1'b0}}, sqrt_root};
	assign diff = (true_q > samp_q) ? (true_q - samp_q) : (samp_q - true_q);
	assign num100 = {1'b0, diff, 6'b0} + {2'b0, diff, 5'b0} + {5'b0, diff, 2'b0};
	assign kval = {1'b0, kq_q} + 33'd1;
	assign pts_sum = {2'b0, pts_q} + {1'b0, kval};
	assign nst_next = {1'b0, tl_q} + {2'b0, per_q};

	// one shared multiplier: squares for distances, scaled offsets for interpolation
	always_comb begin
		case (state_q)
			ST_DSQY: begin
				mul_a = absdiff(ay_q, by_q);
				mul_b = mul_a;
			end
			ST_IMUL: begin
				mul_a = absdiff(ip2, ip1);
				mul_b = {1'b0, ioff};
			end
			default: begin
				mul_a = absdiff(ax_q, bx_q);
				mul_b = mul_a;
			end
		endcase
	end
	assign product = mul_a * mul_b;

	// sequencer
	always_comb begin
		state_d = state_q;
		div_req.start = 1'b0;
		div_req.num = '0;
		div_req.den = '0;
		sqrt_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					if (!seen_q) begin
						div_req.start = 1'b1;
						div_req.num = {41'b0, s_tdata[94:64]};
						div_req.den = {17'b0, per_in};
						state_d = ST_FDIV;
					end else begin
						state_d = ST_DSQX;
					end
				end
			end
			ST_FDIV: if (div_rsp.done) state_d = ST_FIN;
			ST_DSQX: state_d = ST_DSQY;
			ST_DSQY: begin
				sqrt_start = 1'b1;
				state_d = ST_DROOT;
			end
			ST_DROOT: begin
				if (sqrt_done) begin
					case (ret_q)
						RET_TRUE: begin
							if (sample_ok) begin
								div_req.start = 1'b1;
								div_req.num = {40'b0, ({1'b0, cur_st_q} - 32'd1 - nst_q)};
								div_req.den = {17'b0, per_q};
								state_d = ST_KDIV;
							end else begin
								state_d = ST_FIN;
							end
						end
						RET_S1: state_d = ST_DSQX;
						RET_S2: state_d = ST_FIN;
						default: state_d = ST_PCT;
					endcase
				end
			end
			ST_KDIV: if (div_rsp.done) state_d = ST_IMUL;
			ST_IMUL: state_d = ST_IADD;
			ST_IADD: begin
				div_req.start = 1'b1;
				div_req.num = {6'b0, prod_q + {35'b0, dt[31:1]}};
				div_req.den = {16'b0, dt};
				state_d = ST_IDIV;
			end
			ST_IDIV: begin
				if (div_rsp.done) state_d = (idx_q == 2'd3) ? ST_DSQX : ST_IMUL;
			end
			ST_FIN: state_d = cur_fin_q ? ST_DSQX : ST_IDLE;
			ST_PCT: begin
				if (true_q == '0 || diff >= true_q) begin
					state_d = ST_OUT;
				end else begin
					div_req.start = 1'b1;
					div_req.num = {1'b0, num100, 16'b0};
					div_req.den = true_q;
					state_d = ST_PCTDIV;
				end
			end
			ST_PCTDIV: if (div_rsp.done) state_d = ST_OUT;
			ST_OUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= 31'd1;
			seen_q <= 1'b0;
			ret_q <= RET_TRUE;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) period_q <= cfg_wr_data;
			if (m_tvalid && m_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						seen_q <= 1'b1;
						ret_q <= RET_TRUE;
					end
				end
				ST_KDIV: idx_q <= '0;
				ST_IDIV: begin
					if (div_rsp.done) begin
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) ret_q <= RET_S1;
					end
				end
				ST_DROOT: if (sqrt_done && ret_q == RET_S1) ret_q <= RET_S2;
				ST_FIN: ret_q <= RET_FINAL;
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						seen_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					cur_x_q <= s_tdata[31:0];
					cur_y_q <= s_tdata[63:32];
					cur_st_q <= s_tdata[94:64];
					cur_fin_q <= s_tlast;
					per_q <= per_in;
					ax_q <= prev_x_q;
					ay_q <= prev_y_q;
					bx_q <= s_tdata[31:0];
					by_q <= s_tdata[63:32];
					if (!seen_q) begin
						true_q <= '0;
						samp_q <= '0;
						pts_q <= 32'd1;
						sl_x_q <= s_tdata[31:0];
						sl_y_q <= s_tdata[63:32];
					end
				end
			end
			ST_FDIV: begin
				if (div_rsp.done) begin
					nst_q <= {1'b0, cur_st_q} - div_rsp.rem[31:0] + {1'b0, per_q};
				end
			end
			ST_DSQX: prod_q <= product;
			ST_DROOT: begin
				if (sqrt_done) begin
					case (ret_q)
						RET_TRUE: true_q <= len_add(true_q, dist_len);
						RET_S1: begin
							samp_q <= len_add(samp_q, dist_len);
							ax_q <= fx_q;
							ay_q <= fy_q;
							bx_q <= lx_q;
							by_q <= ly_q;
						end
						RET_S2: begin
							samp_q <= len_add(samp_q, dist_len);
							sl_x_q <= lx_q;
							sl_y_q <= ly_q;
							pts_q <= (pts_sum >= {2'b0, CNT_MAX}) ? CNT_MAX : pts_sum[31:0];
							nst_q <= nst_next[31:0];
						end
						default: samp_q <= len_add(samp_q, dist_len);
					endcase
				end
			end
			ST_KDIV: begin
				if (div_rsp.done) begin
					kq_q <= div_rsp.quo[31:0];
					tl_q <= {1'b0, cur_st_q} - 32'd1 - div_rsp.rem[31:0];
				end
			end
			ST_IMUL: prod_q <= product;
			ST_IDIV: begin
				if (div_rsp.done) begin
					case (idx_q)
						2'd0: fx_q <= ires[COORD_W-1:0];
						2'd1: fy_q <= ires[COORD_W-1:0];
						2'd2: lx_q <= ires[COORD_W-1:0];
						default: begin
							ly_q <= ires[COORD_W-1:0];
							ax_q <= sl_x_q;
							ay_q <= sl_y_q;
							bx_q <= fx_q;
							by_q <= fy_q;
						end
					endcase
				end
			end
			ST_FIN: begin
				prev_x_q <= cur_x_q;
				prev_y_q <= cur_y_q;
				prev_st_q <= cur_st_q;
				ax_q <= sl_x_q;
				ay_q <= sl_y_q;
				bx_q <= cur_x_q;
				by_q <= cur_y_q;
			end
			ST_PCT: begin
				fault_q <= (true_q == '0);
				pct_q <= (true_q == '0) ? '0 : PCT_FULL;
			end
			ST_PCTDIV: begin
				if (div_rsp.done) begin
					pct_q <= (div_rsp.quo > {49'b0, PCT_FULL}) ? PCT_FULL
					                                           : div_rsp.quo[PCT_W-1:0];
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_pct_q <= pct_q;
					out_cnt_q <= (pts_q == CNT_MAX) ? CNT_MAX : pts_q + 32'd1;
					out_fault_q <= fault_q;
				end
			end
			default: ;
		endcase
	end

	trlen_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	trlen_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (prod_q + product),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, out_cnt_q, out_pct_q};
	assign m_tuser = out_fault_q;

endmodule

FILE: src/trlen_checker.sv
// Port-level checks for the track resample length error block, with its bind.
module trlen_checker
	import trlen_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tuser
);

	// hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// drop ready for the cycles after a transfer in
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after input transfer");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[PCT_W-1:0] == '0)
		else $error("fault with nonzero percent");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[PCT_W-1:0] <= PCT_FULL && m_tdata[54:23] >= 32'd2)
		else $error("result out of range");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result right after input transfer");

endmodule

bind track_resample_length_error trlen_checker u_trlen_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
